@@ rtl/reno_cw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Reno congestion window block.
// Has no dependencies; every other file in rtl/ refers to it by scoped names.
package reno_cw_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WIN_W = 30;
    localparam int unsigned SEQ_W = 32;
    localparam int unsigned DIV_W = 32;
    localparam int unsigned DIVISOR_W = 30;

    localparam logic [15:0] BASE_MAX_WINDOW = 16'hFFFF;
    localparam logic [3:0] MAX_SCALE = 4'd14;

    localparam logic [15:0] MSS_RESET = 16'd536;
    localparam logic [3:0] SCALE_RESET = 4'd0;
    localparam logic [3:0] THRESH_RESET = 4'd3;
    localparam logic [WIN_W-1:0] CWND_RESET = 30'd536;
    localparam logic [WIN_W-1:0] SSTHRESH_RESET = 30'd1073725440;
    localparam logic [7:0] DUP_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SEGMENT = 2'd0,
        CFG_WINDOW_SCALE = 2'd1,
        CFG_DUP_THRESHOLD = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_DUP_ACK = 1'b0,
        CMD_NEW_ACK = 1'b1
    } cmd_t;

    // Saturate a grown window at 65535 shifted by the (clamped) window scale.
    function automatic logic [WIN_W-1:0] cap_window(input logic [32:0] value,
                                                     input logic [3:0] scale);
        logic [3:0] shift;
        logic [WIN_W-1:0] limit;
        shift = (scale > MAX_SCALE) ? MAX_SCALE : scale;
        limit = {14'd0, BASE_MAX_WINDOW} << shift;
        return (value > {3'd0, limit}) ? limit : value[WIN_W-1:0];
    endfunction

endpackage

@@ rtl/reno_cw_div.sv @@
`timescale 1ns / 1ps
// Iterative restoring divider: one quotient bit per cycle.
// Uses reno_cw_pkg for the operand widths.
module reno_cw_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [reno_cw_pkg::DIV_W-1:0]        dividend,
    input  logic [reno_cw_pkg::DIVISOR_W-1:0]    divisor,
    output logic                                 done,
    output logic [reno_cw_pkg::DIV_W-1:0]        quotient
);

    logic [reno_cw_pkg::DIV_W-1:0]     quo_reg;
    logic [reno_cw_pkg::DIVISOR_W-1:0] rem_reg;
    logic [reno_cw_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [4:0]                        count_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic [reno_cw_pkg::DIVISOR_W:0]   shifted;
    logic [reno_cw_pkg::DIVISOR_W+1:0] trial;

    assign shifted = {rem_reg, quo_reg[reno_cw_pkg::DIV_W-1]};
    assign trial = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= '0;
            count_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
                count_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // A borrow out of the trial subtraction means the divisor did not fit.
                if (trial[reno_cw_pkg::DIVISOR_W+1])
                begin
                    rem_reg <= shifted[reno_cw_pkg::DIVISOR_W-1:0];
                    quo_reg <= {quo_reg[reno_cw_pkg::DIV_W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[reno_cw_pkg::DIVISOR_W-1:0];
                    quo_reg <= {quo_reg[reno_cw_pkg::DIV_W-2:0], 1'b1};
                end
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/reno_congestion_window_core.sv @@
`timescale 1ns / 1ps
// Top level of the Reno congestion window block: sequencer, state and output register.
// Depends on reno_cw_pkg and the shared divider reno_cw_div.
//
// Usage: one ACK event enters per item on the input channel (in_valid / in_stall)
// and exactly one result item leaves on the output channel (out_valid / out_stall).
// in_stall is high while an item is being worked on; the block takes one item at
// a time. A duplicate ACK below or beyond the threshold passes through ST_DECIDE and
// ST_WRITE, and a slow-start new ACK through ST_DECIDE, ST_GROW and ST_WRITE. Fast
// retransmit (count reaching the threshold) and a new ACK in congestion avoidance
// each run one pass of the shared divider. The divider is the only long path and
// sets the worst case. The result sits in an output register, so a new item is
// accepted while the previous result still waits; if the receiver stalls when
// the next result is ready, the sequencer holds it until the register frees.
// The user is to write configuration (cfg_we, cfg_index, cfg_data) only while idle;
// the block itself does not enforce this.
// Reset returns the registers to mss 536, scale 0, threshold 3, the window to
// 536 bytes, the threshold to 1073725440 bytes and the duplicate count to zero.
module reno_congestion_window_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [reno_cw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [reno_cw_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [31:0]                          ack_seq,
    input  logic [29:0]                          peer_window,
    input  logic [31:0]                          send_next,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [29:0]                          cong_window,
    output logic [29:0]                          slow_start_limit,
    output logic                                 do_retransmit,
    output logic [31:0]                          retransmit_seq,
    output logic [31:0]                          new_send_next,
    output logic                                 stop_timer,
    output logic                                 try_send
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEG_DIV,
        ST_SEG_MUL,
        ST_INFL_MUL,
        ST_INFL_ADD,
        ST_AVOID_DIV,
        ST_GROW,
        ST_WRITE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [15:0] max_segment_reg;
    logic [3:0]  window_scale_reg;
    logic [3:0]  dup_threshold_reg;

    // Connection state.
    logic [29:0] cwnd_reg;
    logic [29:0] ssth_reg;
    logic [7:0]  dup_reg;

    // Latched item and working values.
    logic        cmd_reg;
    logic [31:0] ack_reg;
    logic [29:0] peer_reg;
    logic [31:0] snd_reg;
    logic [28:0] segs_reg;
    logic [23:0] infl_reg;
    logic [31:0] incr_reg;

    logic        res_retx_reg;
    logic [31:0] res_rseq_reg;
    logic [31:0] res_nnext_reg;
    logic        res_stop_reg;
    logic        res_send_reg;

    // Output register.
    logic        out_valid_reg;
    logic [29:0] cong_window_reg;
    logic [29:0] slow_start_limit_reg;
    logic        do_retransmit_reg;
    logic [31:0] retransmit_seq_reg;
    logic [31:0] new_send_next_reg;
    logic        stop_timer_reg;
    logic        try_send_reg;

    logic [15:0] mss_eff;
    logic [3:0]  thr_eff;
    logic [7:0]  dup_inc;
    logic        dup_above;
    logic        dup_equal;
    logic        was_recovering;
    logic [29:0] win_min;
    logic [29:0] cwnd_defl;
    logic        avoid;
    logic [31:0] mss_sq;
    logic [44:0] seg_prod;
    logic [23:0] infl_prod;
    logic [31:0] after_seq;
    logic [31:0] seq_diff;
    logic        keep_next;
    logic [32:0] step_sum;
    logic [32:0] infl_sum;
    logic [32:0] grow_sum;
    logic        out_free;

    logic                                  div_start;
    logic [reno_cw_pkg::DIV_W-1:0]         div_dividend;
    logic [reno_cw_pkg::DIVISOR_W-1:0]     div_divisor;
    logic                                  div_done;
    logic [reno_cw_pkg::DIV_W-1:0]         div_quotient;

    always_comb
    begin
        mss_eff = (max_segment_reg == 16'd0) ? 16'd1 : max_segment_reg;
        thr_eff = (dup_threshold_reg == 4'd0) ? 4'd1 : dup_threshold_reg;
        dup_inc = (dup_reg == reno_cw_pkg::DUP_MAX) ? dup_reg : dup_reg + 8'd1;
        dup_above = dup_inc > {4'd0, thr_eff};
        dup_equal = dup_inc == {4'd0, thr_eff};
        was_recovering = dup_reg > {4'd0, thr_eff};
        win_min = (peer_reg < cwnd_reg) ? peer_reg : cwnd_reg;
        cwnd_defl = (was_recovering && (cwnd_reg > ssth_reg)) ? ssth_reg : cwnd_reg;
        avoid = cwnd_defl > ssth_reg;
        mss_sq = {16'd0, mss_eff} * {16'd0, mss_eff};
        seg_prod = {16'd0, segs_reg} * {29'd0, mss_eff};
        infl_prod = {8'd0, mss_eff} * {16'd0, dup_reg};
        after_seq = ack_reg + {16'd0, mss_eff};
        seq_diff = snd_reg - after_seq;
        keep_next = (seq_diff != 32'd0) && !seq_diff[31];
        step_sum = {3'd0, cwnd_reg} + {17'd0, mss_eff};
        infl_sum = {3'd0, ssth_reg} + {9'd0, infl_reg};
        grow_sum = {3'd0, cwnd_reg} + {1'b0, incr_reg};
        out_free = !out_valid_reg || !out_stall;
    end

    // The divider serves both the ssthresh segment count and the avoidance step.
    always_comb
    begin
        div_start = 1'b0;
        if (state_reg == ST_DECIDE)
        begin
            if (cmd_reg == reno_cw_pkg::CMD_NEW_ACK)
            begin
                div_start = avoid;
            end
            else
            begin
                div_start = dup_equal;
            end
        end
        if (cmd_reg == reno_cw_pkg::CMD_NEW_ACK)
        begin
            div_dividend = mss_sq;
            div_divisor = cwnd_defl;
        end
        else
        begin
            div_dividend = {3'd0, win_min[29:1]};
            div_divisor = {14'd0, mss_eff};
        end
    end

    reno_cw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            max_segment_reg <= reno_cw_pkg::MSS_RESET;
            window_scale_reg <= reno_cw_pkg::SCALE_RESET;
            dup_threshold_reg <= reno_cw_pkg::THRESH_RESET;
            cwnd_reg <= reno_cw_pkg::CWND_RESET;
            ssth_reg <= reno_cw_pkg::SSTHRESH_RESET;
            dup_reg <= '0;
            cmd_reg <= 1'b0;
            ack_reg <= '0;
            peer_reg <= '0;
            snd_reg <= '0;
            segs_reg <= '0;
            infl_reg <= '0;
            incr_reg <= '0;
            res_retx_reg <= 1'b0;
            res_rseq_reg <= '0;
            res_nnext_reg <= '0;
            res_stop_reg <= 1'b0;
            res_send_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cong_window_reg <= '0;
            slow_start_limit_reg <= '0;
            do_retransmit_reg <= 1'b0;
            retransmit_seq_reg <= '0;
            new_send_next_reg <= '0;
            stop_timer_reg <= 1'b0;
            try_send_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == reno_cw_pkg::CFG_MAX_SEGMENT)
                begin
                    max_segment_reg <= cfg_data;
                end
                else if (cfg_index == reno_cw_pkg::CFG_WINDOW_SCALE)
                begin
                    window_scale_reg <= cfg_data[3:0];
                end
                else if (cfg_index == reno_cw_pkg::CFG_DUP_THRESHOLD)
                begin
                    dup_threshold_reg <= cfg_data[3:0];
                end
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= command;
                        ack_reg <= ack_seq;
                        peer_reg <= peer_window;
                        snd_reg <= send_next;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    res_retx_reg <= 1'b0;
                    res_rseq_reg <= '0;
                    res_nnext_reg <= snd_reg;
                    res_stop_reg <= 1'b0;
                    res_send_reg <= 1'b0;
                    if (cmd_reg == reno_cw_pkg::CMD_NEW_ACK)
                    begin
                        cwnd_reg <= cwnd_defl;
                        dup_reg <= '0;
                        res_send_reg <= 1'b1;
                        if (avoid)
                        begin
                            state_reg <= ST_AVOID_DIV;
                        end
                        else
                        begin
                            incr_reg <= {16'd0, mss_eff};
                            state_reg <= ST_GROW;
                        end
                    end
                    else
                    begin
                        dup_reg <= dup_inc;
                        if (dup_above)
                        begin
                            // Window inflation during fast recovery.
                            cwnd_reg <= reno_cw_pkg::cap_window(step_sum, window_scale_reg);
                            res_send_reg <= 1'b1;
                            state_reg <= ST_WRITE;
                        end
                        else if (dup_equal)
                        begin
                            state_reg <= ST_SEG_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_SEG_DIV:
                begin
                    if (div_done)
                    begin
                        segs_reg <= (div_quotient < 32'd2) ? 29'd2 : div_quotient[28:0];
                        state_reg <= ST_SEG_MUL;
                    end
                end
                ST_SEG_MUL:
                begin
                    ssth_reg <= seg_prod[29:0];
                    state_reg <= ST_INFL_MUL;
                end
                ST_INFL_MUL:
                begin
                    infl_reg <= infl_prod;
                    state_reg <= ST_INFL_ADD;
                end
                ST_INFL_ADD:
                begin
                    cwnd_reg <= reno_cw_pkg::cap_window(infl_sum, window_scale_reg);
                    res_retx_reg <= 1'b1;
                    res_rseq_reg <= ack_reg;
                    res_nnext_reg <= keep_next ? snd_reg : after_seq;
                    res_stop_reg <= 1'b1;
                    state_reg <= ST_WRITE;
                end
                ST_AVOID_DIV:
                begin
                    if (div_done)
                    begin
                        incr_reg <= div_quotient;
                        state_reg <= ST_GROW;
                    end
                end
                ST_GROW:
                begin
                    cwnd_reg <= reno_cw_pkg::cap_window(grow_sum, window_scale_reg);
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        cong_window_reg <= cwnd_reg;
                        slow_start_limit_reg <= ssth_reg;
                        do_retransmit_reg <= res_retx_reg;
                        retransmit_seq_reg <= res_rseq_reg;
                        new_send_next_reg <= res_nnext_reg;
                        stop_timer_reg <= res_stop_reg;
                        try_send_reg <= res_send_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cong_window = cong_window_reg;
    assign slow_start_limit = slow_start_limit_reg;
    assign do_retransmit = do_retransmit_reg;
    assign retransmit_seq = retransmit_seq_reg;
    assign new_send_next = new_send_next_reg;
    assign stop_timer = stop_timer_reg;
    assign try_send = try_send_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for reno_congestion_window_core: ACK items go in, window results are
// predicted here and compared field by field. Depends on reno_cw_pkg and the block's RTL only.
module tb;

    localparam logic [reno_cw_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        reno_cw_pkg::cmd_t cmd;
        logic [31:0]       ack;
        logic [29:0]       peer;
        logic [31:0]       snext;
    } ack_event_t;

    typedef struct packed {
        logic [29:0] cong_win;
        logic [29:0] ss_limit;
        logic        retx;
        logic [31:0] retx_seq;
        logic [31:0] next_seq;
        logic        stop;
        logic        send;
    } ack_result_t;

    typedef struct {
        logic                              is_cfg;
        logic [reno_cw_pkg::CFG_IDX_W-1:0] index;
        logic [15:0]                       data;
        ack_event_t                        ev;
        logic                              known;
        ack_result_t                       want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [reno_cw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [reno_cw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] ack_seq;
    logic [29:0] peer_window;
    logic [31:0] send_next;
    logic        out_valid;
    logic        out_stall;
    logic [29:0] cong_window;
    logic [29:0] slow_start_limit;
    logic        do_retransmit;
    logic [31:0] retransmit_seq;
    logic [31:0] new_send_next;
    logic        stop_timer;
    logic        try_send;

    // Mirror of the block's registers and connection state.
    logic [15:0] cfg_mss;
    logic [3:0]  cfg_scale;
    logic [3:0]  cfg_thr;
    logic [31:0] cwnd_now;
    logic [31:0] ssthresh_now;
    int unsigned dup_seen;

    ack_result_t pending_windows[$];
    plan_row_t   plan[$];
    int          errors;
    int          cycles;
    bit          steady_flow;

    reno_congestion_window_core uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .ack_seq          (ack_seq),
        .peer_window      (peer_window),
        .send_next        (send_next),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cong_window      (cong_window),
        .slow_start_limit (slow_start_limit),
        .do_retransmit    (do_retransmit),
        .retransmit_seq   (retransmit_seq),
        .new_send_next    (new_send_next),
        .stop_timer       (stop_timer),
        .try_send         (try_send)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] window_limit(input logic [63:0] v);
        logic [3:0]  sh;
        logic [63:0] lim;
        sh = (cfg_scale > reno_cw_pkg::MAX_SCALE) ? reno_cw_pkg::MAX_SCALE : cfg_scale;
        lim = {48'd0, reno_cw_pkg::BASE_MAX_WINDOW} << sh;
        return (v > lim) ? lim[31:0] : v[31:0];
    endfunction

    // Advances the mirrored connection state by one ACK item and returns its result.
    function automatic ack_result_t reno_next_window(input ack_event_t ev);
        ack_result_t r;
        logic [63:0] m;
        logic [63:0] w;
        logic [63:0] segs;
        logic [63:0] incr;
        logic [31:0] after;
        logic [31:0] lead;
        int unsigned thr;
        m = (cfg_mss == 16'd0) ? 64'd1 : {48'd0, cfg_mss};
        thr = (cfg_thr == 4'd0) ? 1 : cfg_thr;
        r = '0;
        r.next_seq = ev.snext;
        if (ev.cmd == reno_cw_pkg::CMD_DUP_ACK)
        begin
            if (dup_seen < 255)
                dup_seen++;
            if (dup_seen > thr)
            begin
                cwnd_now = window_limit(cwnd_now + m);
                r.send = 1'b1;
            end
            else if (dup_seen == thr)
            begin
                w = ({2'b00, ev.peer} < cwnd_now) ? {34'd0, ev.peer} : {32'd0, cwnd_now};
                segs = (w / 2) / m;
                if (segs < 2)
                    segs = 2;
                ssthresh_now = 32'(segs * m);
                cwnd_now = window_limit({32'd0, ssthresh_now} + m * dup_seen);
                r.retx = 1'b1;
                r.retx_seq = ev.ack;
                after = ev.ack + m[31:0];
                // Keep send_next only if it lies strictly ahead of the resent segment.
                lead = ev.snext - after;
                r.next_seq = (lead != 32'd0 && lead < 32'h8000_0000) ? ev.snext : after;
                r.stop = 1'b1;
            end
        end
        else
        begin
            // Leaving fast recovery deflates the inflated window back to ssthresh.
            if (dup_seen > thr && cwnd_now > ssthresh_now)
                cwnd_now = ssthresh_now;
            dup_seen = 0;
            if (cwnd_now > ssthresh_now)
                incr = (m * m) / cwnd_now;
            else
                incr = m;
            cwnd_now = window_limit(cwnd_now + incr);
            r.send = 1'b1;
        end
        r.cong_win = cwnd_now[29:0];
        r.ss_limit = ssthresh_now[29:0];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic ack_event_t make_event(input reno_cw_pkg::cmd_t c);
        ack_event_t ev;
        int unsigned m;
        m = (cfg_mss == 16'd0) ? 1 : cfg_mss;
        ev.cmd = c;
        ev.ack = $urandom();
        case ($urandom_range(0, 3))
            0: ev.peer = 30'($urandom());
            1: ev.peer = 30'($urandom_range(0, 4 * cwnd_now[29:0] + 4));
            2: ev.peer = 30'($urandom_range(0, 300000));
            default: ev.peer = $urandom_range(0, 1) ? '1 : '0;
        endcase
        case ($urandom_range(0, 3))
            0: ev.snext = ev.ack + $urandom_range(0, 4 * m);
            1: ev.snext = ev.ack + m;
            2: ev.snext = $urandom();
            default: ev.snext = ev.ack + m + 32'h7FFF_FFFF + $urandom_range(0, 2);
        endcase
        return ev;
    endfunction

    function automatic void plan_cfg(input logic [reno_cw_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [15:0] data);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.index = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input reno_cw_pkg::cmd_t c, input logic [31:0] ack,
                                      input logic [29:0] peer, input logic [31:0] snext,
                                      input logic known, input ack_result_t want);
        plan_row_t row;
        row = '{default: '0};
        row.ev.cmd = c;
        row.ev.ack = ack;
        row.ev.peer = peer;
        row.ev.snext = snext;
        row.known = known;
        row.want = want;
        plan.push_back(row);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Sends one item; its expectation is queued at the edge where it is taken.
    task automatic send_event(input ack_event_t ev, input logic known, input ack_result_t want);
        int gap;
        ack_result_t got;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command <= ev.cmd;
        ack_seq <= ev.ack;
        peer_window <= ev.peer;
        send_next <= ev.snext;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = reno_next_window(ev);
        pending_windows.push_back(known ? want : got);
    endtask

    task automatic drain_pending();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [reno_cw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        drain_pending();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            reno_cw_pkg::CFG_MAX_SEGMENT: cfg_mss = data;
            reno_cw_pkg::CFG_WINDOW_SCALE: cfg_scale = data[3:0];
            reno_cw_pkg::CFG_DUP_THRESHOLD: cfg_thr = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int quota, input bit with_long_run);
        int sent;
        int k;
        int thr_eff;
        sent = 0;
        thr_eff = (cfg_thr == 4'd0) ? 1 : cfg_thr;
        if (with_long_run)
        begin
            // Long enough for the duplicate count to saturate.
            repeat (300)
                send_event(make_event(reno_cw_pkg::CMD_DUP_ACK), 1'b0, '0);
            send_event(make_event(reno_cw_pkg::CMD_NEW_ACK), 1'b0, '0);
        end
        while (sent < quota)
        begin
            k = $urandom_range(0, 99);
            if (k < 75)
            begin
                // A few new ACKs, then a run of duplicates around the threshold.
                k = $urandom_range(1, 4);
                repeat (k)
                    send_event(make_event(reno_cw_pkg::CMD_NEW_ACK), 1'b0, '0);
                sent += k;
                if ($urandom_range(0, 99) < 80)
                    k = thr_eff + $urandom_range(0, 4);
                else
                    k = $urandom_range(0, 20);
                repeat (k)
                    send_event(make_event(reno_cw_pkg::CMD_DUP_ACK), 1'b0, '0);
                sent += k;
            end
            else if (k < 97)
            begin
                k = $urandom_range(1, 8);
                repeat (k)
                    send_event(make_event(reno_cw_pkg::cmd_t'($urandom_range(0, 1))),
                               1'b0, '0);
                sent += k;
            end
            else
            begin
                drain_pending();
            end
        end
    endtask

    initial
    begin : out_stall_gen
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = idle_len() + 1;
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            n = idle_len();
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        ack_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                $error("result item arrived with nothing pending");
                errors++;
            end
            else
            begin
                want = pending_windows.pop_front();
                check_field("cong_window", 32'(want.cong_win), 32'(cong_window));
                check_field("slow_start_limit", 32'(want.ss_limit), 32'(slow_start_limit));
                check_field("do_retransmit", 32'(want.retx), 32'(do_retransmit));
                check_field("retransmit_seq", want.retx_seq, retransmit_seq);
                check_field("new_send_next", want.next_seq, new_send_next);
                check_field("stop_timer", 32'(want.stop), 32'(stop_timer));
                check_field("try_send", 32'(want.send), 32'(try_send));
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] mss_d;
        logic [15:0] scale_d;
        logic [15:0] thr_d;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = 1'b0;
        ack_seq = '0;
        peer_window = '0;
        send_next = '0;
        errors = 0;
        steady_flow = 1'b0;
        cfg_mss = 16'd536;
        cfg_scale = 4'd0;
        cfg_thr = 4'd3;
        cwnd_now = 32'd536;
        ssthresh_now = 32'd1073725440;
        dup_seen = 0;

        // Reset defaults: mss 536, threshold 3, window capped at 65535.
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'h0, 30'h0, 32'h0, 1'b1,
                  {30'd1072, 30'd1073725440, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1});
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                  {30'd1072, 30'd1073725440, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0});
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0000_0001, 30'd1000, 32'h0000_0002, 1'b1,
                  {30'd1072, 30'd1073725440, 1'b0, 32'd0, 32'h0000_0002, 1'b0, 1'b0});
        // Third duplicate: fast retransmit, the resent segment end wraps past zero.
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'hFFFF_FF00, 30'h3FFF_FFFF, 32'h0000_0100, 1'b1,
                  {30'd2680, 30'd1072, 1'b1, 32'hFFFF_FF00, 32'h0000_0118, 1'b1, 1'b0});
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h0, 32'h0, 1'b1,
                  {30'd3216, 30'd1072, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1});
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                  {30'd1608, 30'd1072, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1});
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'h1234_5678, 30'h2000_0000, 32'h1234_5678,
                  1'b0, '0);
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h0, 32'hFFFF_FFFF, 1'b0, '0);
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h0, 32'hFFFF_FFFF, 1'b0, '0);
        // A zero peer window at the threshold falls back to two segments.
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h0, 32'h8000_0000, 1'b0, '0);
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'h0, 30'h0, 32'h0, 1'b0, '0);
        // Zero segment size and zero threshold act as one; scale 15 acts as 14.
        plan_cfg(reno_cw_pkg::CFG_MAX_SEGMENT, 16'h0000);
        plan_cfg(reno_cw_pkg::CFG_WINDOW_SCALE, 16'h000F);
        plan_cfg(reno_cw_pkg::CFG_DUP_THRESHOLD, 16'h0000);
        plan_cfg(CFG_SPARE, 16'hFFFF);
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'h7FFF_FFFF,
                  1'b0, '0);
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h0, 32'h0, 1'b0, '0);
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'h0, 30'h0, 32'h0, 1'b0, '0);
        plan_cfg(reno_cw_pkg::CFG_MAX_SEGMENT, 16'hFFFF);
        plan_cfg(reno_cw_pkg::CFG_WINDOW_SCALE, 16'hFFF0);
        plan_cfg(reno_cw_pkg::CFG_DUP_THRESHOLD, 16'h000F);
        // Largest segment against the smallest cap.
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'h0, 30'h3FFF_FFFF, 32'h0, 1'b0, '0);
        plan_item(reno_cw_pkg::CMD_NEW_ACK, 32'hFFFF_FFFF, 30'h0, 32'hFFFF_FFFF, 1'b0, '0);
        plan_item(reno_cw_pkg::CMD_DUP_ACK, 32'h0, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].index, plan[i].data);
            else
                send_event(plan[i].ev, plan[i].known, plan[i].want);
        end

        // Corner settings first, random ones after.
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0:
                begin
                    mss_d = 16'hFFFF;
                    scale_d = 16'd14;
                    thr_d = 16'd15;
                end
                1:
                begin
                    mss_d = 16'd1;
                    scale_d = 16'd0;
                    thr_d = 16'd1;
                end
                2:
                begin
                    mss_d = 16'd0;
                    scale_d = 16'hFFFF;
                    thr_d = 16'hFFF0;
                end
                3:
                begin
                    mss_d = 16'd536;
                    scale_d = 16'd0;
                    thr_d = 16'd3;
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: mss_d = 16'($urandom());
                        1: mss_d = 16'd1460;
                        default: mss_d = 16'($urandom_range(1, 64));
                    endcase
                    scale_d = 16'($urandom());
                    thr_d = 16'($urandom());
                end
            endcase
            write_reg(reno_cw_pkg::CFG_MAX_SEGMENT, mss_d);
            write_reg(reno_cw_pkg::CFG_WINDOW_SCALE, scale_d);
            write_reg(reno_cw_pkg::CFG_DUP_THRESHOLD, thr_d);
            steady_flow = (p == 2) || ($urandom_range(0, 4) == 0);
            run_phase(200, p == 3);
        end

        steady_flow = 1'b0;
        drain_pending();
        repeat (40)
            @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/reno_cw_pkg.sv
rtl/reno_cw_div.sv
rtl/reno_congestion_window_core.sv
verif/tb.sv
